>>> rtl/core/gas_sensor_ppm_converter_assert.svh
// assertion macros for the gas sensor ppm converter checker
// used by gspc_chk.sv, needs i_clk and i_rst_n in scope
`ifndef GAS_SENSOR_PPM_CONVERTER_ASSERT_SVH
`define GAS_SENSOR_PPM_CONVERTER_ASSERT_SVH

// checked on every clock edge outside reset
`define GSPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define GSPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/gspc_pkg.sv
// shared types, constants and tables of the gas sensor ppm converter
// no dependencies; imported by the interfaces and the core modules
package gspc_pkg;

    // field widths
    localparam int ADC_W   = 12;
    localparam int RES_W   = 24;
    localparam int CURVE_W = 48;
    localparam int CFG_W   = 48;
    localparam int SPAN_W  = 17;

    // shared divider geometry
    localparam int DVD_W  = 44;
    localparam int DVS_W  = 24;
    localparam int DIT_W  = 6;

    localparam logic [RES_W-1:0] SAT24 = 24'hFF_FFFF;

    // register indexes
    localparam logic [2:0] CFG_LOAD_RES  = 3'd0;
    localparam logic [2:0] CFG_AIR_FAC   = 3'd1;
    localparam logic [2:0] CFG_CAL_CNT   = 3'd2;
    localparam logic [2:0] CFG_READ_CNT  = 3'd3;
    localparam logic [2:0] CFG_LPG_CURVE = 3'd4;
    localparam logic [2:0] CFG_CO_CURVE  = 3'd5;
    localparam logic [2:0] CFG_SMK_CURVE = 3'd6;

    // item kinds and status codes
    localparam logic       KIND_CAL  = 1'b0;
    localparam logic       KIND_MEAS = 1'b1;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOCAL  = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;

    // 2^(2^-k) in Q30 for k = 1..8
    localparam logic [30:0] POW2_TAB [8] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033
    };
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] LN2_Q30 = 31'd744261118;

    typedef struct packed {
        logic [15:0]        load_res;
        logic [15:0]        air_fac;
        logic [6:0]         cal_cnt;
        logic [6:0]         read_cnt;
        logic [CURVE_W-1:0] lpg;
        logic [CURVE_W-1:0] co;
        logic [CURVE_W-1:0] smoke;
    } t_cfg;

    // classified sample waiting in the queue
    typedef struct packed {
        logic              req_type;
        logic [ADC_W-1:0]  adc;
        logic              is_zero;
        logic              over_fs;
        logic [SPAN_W-1:0] span;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qout;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [4:0] {
        B_IDLE, B_RS_MUL, B_RS_DIV, B_RS_WAIT, B_ACC, B_AVG, B_AVG_WAIT,
        B_RO_DIV, B_RO_WAIT, B_RATIO_DIV, B_RATIO_WAIT, B_NORM,
        B_SQ_MUL, B_SQ_UPD, B_L10_MUL, B_L10_UPD, B_CV_START, B_CV_WAIT,
        B_EXP_MUL, B_EXP_UPD, B_POW_MUL, B_POW_UPD, B_POW_FIN, B_CV_NEXT,
        B_EMIT
    } t_bstate;

    // factor for fraction bit k of the base-2 exponent, Q30
    function automatic logic [30:0] pow2_fac(input logic [4:0] k);
        logic [30:0] f;
        if (k <= 5'd8 && k != 5'd0) begin
            f = POW2_TAB[3'(k - 5'd1)];
        end else begin
            f = ONE_Q30 + (LN2_Q30 >> k);
        end
        return f;
    endfunction

endpackage

>>> rtl/core/gspc_in_if.sv
// sample channel of the gas sensor ppm converter
// depends on gspc_pkg
interface gspc_in_if;
    import gspc_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, req_type, adc_sample, input ready);
    modport sink   (input valid, req_type, adc_sample, output ready);
endinterface

>>> rtl/core/gspc_out_if.sv
// result channel of the gas sensor ppm converter
// depends on gspc_pkg
interface gspc_out_if;
    import gspc_pkg::*;

    logic             valid;
    logic             ready;
    logic             result_kind;
    logic [RES_W-1:0] ro_kohm_q8;
    logic [RES_W-1:0] lpg_ppm;
    logic [RES_W-1:0] co_ppm;
    logic [RES_W-1:0] smoke_ppm;
    logic [1:0]       status;

    modport source (output valid, result_kind, ro_kohm_q8, lpg_ppm, co_ppm,
                    smoke_ppm, status, input ready);
    modport sink   (input valid, result_kind, ro_kohm_q8, lpg_ppm, co_ppm,
                    smoke_ppm, status, output ready);
endinterface

>>> rtl/core/gas_sensor_ppm_converter.sv
// Gas sensor ppm converter. Samples enter through i_item and are queued two
// deep, so up to two samples are taken while a run is being finished. Each
// sample's resistance is formed by the shared 44-step divider unless it is zero
// or at full scale. The last sample of a calibration run adds the average and
// Ro divisions; the last sample of a measurement run adds the average division
// and, once calibrated, the ratio division, normalization, 16 squaring steps,
// and per curve up to one division and up to 16 power steps on the shared
// multiplier. A result waits in the output register until taken. Registers
// must be written through i_cfg_* while the block is idle; it is not enforced.
// depends on gspc_pkg, gspc_in_if, gspc_out_if, gspc_front, gspc_div, gspc_back
module gas_sensor_ppm_converter #(
    parameter int ADC_FULL_SCALE  = 4096,
    parameter int MAX_RUN_SAMPLES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    gspc_in_if.sink                    i_item,
    gspc_out_if.source                 o_result,
    input  logic                       i_cfg_wr_en,
    input  logic [2:0]                 i_cfg_index,
    input  logic [gspc_pkg::CFG_W-1:0] i_cfg_wdata
);
    import gspc_pkg::*;

    t_cfg     r_cfg;
    t_qout    q_out;
    logic     pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_res <= 16'd2560;
            r_cfg.air_fac  <= 16'd2509;
            r_cfg.cal_cnt  <= 7'd50;
            r_cfg.read_cnt <= 7'd5;
            r_cfg.lpg      <= '0;
            r_cfg.co       <= '0;
            r_cfg.smoke    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOAD_RES:  r_cfg.load_res <= i_cfg_wdata[15:0];
                CFG_AIR_FAC:   r_cfg.air_fac  <= i_cfg_wdata[15:0];
                CFG_CAL_CNT:   r_cfg.cal_cnt  <= i_cfg_wdata[6:0];
                CFG_READ_CNT:  r_cfg.read_cnt <= i_cfg_wdata[6:0];
                CFG_LPG_CURVE: r_cfg.lpg      <= i_cfg_wdata;
                CFG_CO_CURVE:  r_cfg.co       <= i_cfg_wdata;
                CFG_SMK_CURVE: r_cfg.smoke    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    gspc_front #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_q     (q_out)
    );

    gspc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    gspc_back #(
        .MAX_RUN_SAMPLES (MAX_RUN_SAMPLES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q      (q_out),
        .o_pop    (pop),
        .o_div    (div_req),
        .i_div    (div_rsp),
        .o_result (o_result)
    );
endmodule

>>> rtl/core/gspc_front.sv
// front end: accepts samples, classifies them and queues them for the back end
// depends on gspc_pkg and gspc_in_if
module gspc_front #(
    parameter int ADC_FULL_SCALE = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gspc_in_if.sink             i_item,
    input  logic                i_pop,
    output gspc_pkg::t_qout     o_q
);
    import gspc_pkg::*;

    localparam logic [SPAN_W-1:0] FS = SPAN_W'(ADC_FULL_SCALE);

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    t_item       cls;

    // classify the incoming sample
    always_comb begin
        cls.req_type = i_item.req_type;
        cls.adc      = i_item.adc_sample;
        cls.is_zero  = (i_item.adc_sample == '0);
        cls.over_fs  = (SPAN_W'(i_item.adc_sample) >= FS);
        cls.span     = FS - SPAN_W'(i_item.adc_sample);
    end

    assign i_item.ready = (r_cnt != 2'd2);
    assign push         = i_item.valid && i_item.ready;
    assign o_q.valid    = (r_cnt != 2'd0);
    assign o_q.item     = r_mem[r_rp];

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

>>> rtl/core/gspc_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on gspc_pkg
module gspc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gspc_pkg::t_div_req  i_req,
    output gspc_pkg::t_div_rsp  o_rsp
);
    import gspc_pkg::*;

    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DIT_W-1:0] r_i;
    logic             r_busy, r_done;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem[DVS_W-1:0], r_q[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_dvs});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    // operand and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == DIT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> rtl/core/gspc_back.sv
// back end: run accumulation, calibration, log and power evaluation
// depends on gspc_pkg and gspc_out_if; drives the shared divider gspc_div through its ports
module gspc_back #(
    parameter int MAX_RUN_SAMPLES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gspc_pkg::t_cfg      i_cfg,
    input  gspc_pkg::t_qout     i_q,
    output logic                o_pop,
    output gspc_pkg::t_div_req  o_div,
    input  gspc_pkg::t_div_rsp  i_div,
    gspc_out_if.source          o_result
);
    import gspc_pkg::*;

    localparam int CW = $clog2(MAX_RUN_SAMPLES + 1);
    localparam int TW = (CW > 7) ? CW : 7;
    localparam logic [TW-1:0] MAX_T = TW'(MAX_RUN_SAMPLES);
    localparam logic signed [53:0] T_SAT = 54'sd1572864;

    t_bstate r_state, n_state;

    // run state
    logic              r_run_kind, r_zs, r_cal;
    logic [31:0]       r_sum;
    logic [CW-1:0]     r_cnt;
    logic [RES_W-1:0]  r_ro;

    // per item and per run working registers
    logic              r_kind;
    logic [ADC_W-1:0]  r_adc;
    logic [SPAN_W-1:0] r_span;
    logic [RES_W-1:0]  r_rs;
    logic [31:0]       r_avg;
    logic [DVD_W-1:0]  r_norm;
    logic [5:0]        r_p;
    logic [31:0]       r_m;
    logic [15:0]       r_frac;
    logic [3:0]        r_sq_i;
    logic signed [17:0] r_lg;
    logic [1:0]        r_ci;
    logic              r_neg;
    logic signed [31:0] r_e;
    logic [4:0]        r_ip;
    logic [15:0]       r_f;
    logic [31:0]       r_acc;
    logic [4:0]        r_k;
    logic [RES_W-1:0]  r_ppm [3];
    logic [1:0]        r_status;
    logic signed [65:0] r_prod;

    // output register
    logic              r_out_valid, r_o_kind;
    logic [RES_W-1:0]  r_o_ro, r_o_lpg, r_o_co, r_o_smk;
    logic [1:0]        r_o_status;

    // combinational helpers
    logic signed [32:0] mul_a, mul_b;
    logic [CW-1:0]      cnt_inc;
    logic [6:0]         cnt_cfg;
    logic [TW-1:0]      tgt;
    logic [32:0]        sum_ext;
    logic [CURVE_W-1:0] curve;
    logic signed [15:0] cv_x, cv_y, cv_slope;
    logic signed [18:0] d;
    logic [18:0]        d_mag;
    logic [15:0]        s_mag;
    logic [6:0]         pm12;
    logic [22:0]        l2;
    logic [32:0]        sq;
    logic signed [53:0] t_val;
    logic [54:0]        acc_sh;
    logic [24:0]        v25;
    logic [15:0]        fac_eff;
    logic [DVD_W-1:0]   q;
    logic               out_free;

    assign q        = i_div.quotient;
    assign out_free = !r_out_valid || o_result.ready;

    // run length target with clamping
    always_comb begin
        cnt_inc = r_cnt + 1'b1;
        cnt_cfg = r_kind ? i_cfg.read_cnt : i_cfg.cal_cnt;
        if (cnt_cfg == '0) begin
            tgt = TW'(1);
        end else if (TW'(cnt_cfg) > MAX_T) begin
            tgt = MAX_T;
        end else begin
            tgt = TW'(cnt_cfg);
        end
        sum_ext = {1'b0, r_sum} + 33'(r_rs);
        fac_eff = (i_cfg.air_fac == '0) ? 16'd1 : i_cfg.air_fac;
    end

    // curve fields and exponent terms
    always_comb begin
        unique case (r_ci)
            2'd0:    curve = i_cfg.lpg;
            2'd1:    curve = i_cfg.co;
            default: curve = i_cfg.smoke;
        endcase
        cv_x     = $signed(curve[15:0]);
        cv_y     = $signed(curve[31:16]);
        cv_slope = $signed(curve[47:32]);
        d        = 19'(r_lg) - 19'(cv_y);
        d_mag    = d[18] ? 19'(-d) : 19'(d);
        s_mag    = cv_slope[15] ? 16'(-cv_slope) : 16'(cv_slope);
        pm12     = 7'({1'b0, r_p}) - 7'd12;
        l2       = {pm12, r_frac};
        sq       = r_prod[63:31];
        t_val    = r_prod[65:12];
        acc_sh   = 55'(r_acc) << r_ip;
        v25      = acc_sh[54:30];
    end

    // shared multiplier, product registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            B_RS_MUL: begin
                mul_a = $signed(33'(i_cfg.load_res));
                mul_b = $signed(33'(r_span));
            end
            B_SQ_MUL: begin
                mul_a = $signed(33'(r_m));
                mul_b = $signed(33'(r_m));
            end
            B_L10_MUL: begin
                mul_a = 33'($signed(l2));
                mul_b = 33'sd19728;
            end
            B_EXP_MUL: begin
                mul_a = 33'(r_e);
                mul_b = 33'sd217706;
            end
            B_POW_MUL: begin
                mul_a = $signed(33'(r_acc));
                mul_b = $signed(33'(pow2_fac(r_k)));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, queue pop and divider requests
    always_comb begin
        n_state        = r_state;
        o_pop          = 1'b0;
        o_div.start    = 1'b0;
        o_div.dividend = '0;
        o_div.divisor  = '0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q.valid) begin
                    o_pop = 1'b1;
                    if (i_q.item.is_zero || i_q.item.over_fs) begin
                        n_state = B_ACC;
                    end else begin
                        n_state = B_RS_MUL;
                    end
                end
            end
            B_RS_MUL: n_state = B_RS_DIV;
            B_RS_DIV: begin
                o_div.start    = 1'b1;
                o_div.dividend = DVD_W'(r_prod[32:0]);
                o_div.divisor  = DVS_W'(r_adc);
                n_state        = B_RS_WAIT;
            end
            B_RS_WAIT: if (i_div.done) n_state = B_ACC;
            B_ACC: begin
                n_state = (TW'(cnt_inc) >= tgt) ? B_AVG : B_IDLE;
            end
            B_AVG: begin
                o_div.start    = 1'b1;
                o_div.dividend = DVD_W'(r_sum);
                o_div.divisor  = DVS_W'(r_cnt);
                n_state        = B_AVG_WAIT;
            end
            B_AVG_WAIT: begin
                if (i_div.done) begin
                    if (r_kind == KIND_CAL) begin
                        n_state = B_RO_DIV;
                    end else if (!r_cal || r_ro == '0) begin
                        n_state = B_EMIT;
                    end else begin
                        n_state = B_RATIO_DIV;
                    end
                end
            end
            B_RO_DIV: begin
                o_div.start    = 1'b1;
                o_div.dividend = DVD_W'({r_avg, 8'd0});
                o_div.divisor  = DVS_W'(fac_eff);
                n_state        = B_RO_WAIT;
            end
            B_RO_WAIT: if (i_div.done) n_state = B_EMIT;
            B_RATIO_DIV: begin
                o_div.start    = 1'b1;
                o_div.dividend = {r_avg, 12'd0};
                o_div.divisor  = r_ro;
                n_state        = B_RATIO_WAIT;
            end
            B_RATIO_WAIT: if (i_div.done) n_state = B_NORM;
            B_NORM: if (r_norm[DVD_W-1]) n_state = B_SQ_MUL;
            B_SQ_MUL: n_state = B_SQ_UPD;
            B_SQ_UPD: n_state = (r_sq_i == 4'd15) ? B_L10_MUL : B_SQ_MUL;
            B_L10_MUL: n_state = B_L10_UPD;
            B_L10_UPD: n_state = B_CV_START;
            B_CV_START: begin
                if (cv_slope == '0) begin
                    n_state = B_CV_NEXT;
                end else begin
                    o_div.start    = 1'b1;
                    o_div.dividend = DVD_W'({d_mag, 12'd0});
                    o_div.divisor  = DVS_W'(s_mag);
                    n_state        = B_CV_WAIT;
                end
            end
            B_CV_WAIT: if (i_div.done) n_state = B_EXP_MUL;
            B_EXP_MUL: n_state = B_EXP_UPD;
            B_EXP_UPD: begin
                if (t_val[53] || t_val >= T_SAT) begin
                    n_state = B_CV_NEXT;
                end else begin
                    n_state = B_POW_MUL;
                end
            end
            B_POW_MUL: n_state = B_POW_UPD;
            B_POW_UPD: n_state = (r_k == 5'd16) ? B_POW_FIN : B_POW_MUL;
            B_POW_FIN: n_state = B_CV_NEXT;
            B_CV_NEXT: n_state = (r_ci == 2'd2) ? B_EMIT : B_CV_START;
            B_EMIT: if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // run state, working registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_kind  <= KIND_CAL;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_zs        <= 1'b0;
            r_ro        <= '0;
            r_cal       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_q.valid) begin
                        r_kind <= i_q.item.req_type;
                        r_adc  <= i_q.item.adc;
                        r_span <= i_q.item.span;
                        if (i_q.item.req_type != r_run_kind) begin
                            r_run_kind <= i_q.item.req_type;
                            r_sum      <= '0;
                            r_cnt      <= '0;
                            r_zs       <= 1'b0;
                        end
                        if (i_q.item.is_zero) begin
                            r_rs <= SAT24;
                            r_zs <= 1'b1;
                        end else if (i_q.item.over_fs) begin
                            r_rs <= '0;
                        end
                    end
                end
                B_RS_WAIT: begin
                    if (i_div.done) begin
                        r_rs <= (q > DVD_W'(SAT24)) ? SAT24 : q[RES_W-1:0];
                    end
                end
                B_ACC: begin
                    r_sum <= sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
                    r_cnt <= cnt_inc;
                end
                B_AVG_WAIT: begin
                    if (i_div.done) begin
                        r_avg    <= q[31:0];
                        r_ppm[0] <= '0;
                        r_ppm[1] <= '0;
                        r_ppm[2] <= '0;
                        r_status <= ST_NOCAL;
                    end
                end
                B_RO_WAIT: begin
                    if (i_div.done) begin
                        if (q > DVD_W'(SAT24)) begin
                            r_ro  <= SAT24;
                            r_cal <= 1'b1;
                        end else begin
                            r_ro  <= q[RES_W-1:0];
                            r_cal <= (q != '0);
                        end
                        r_status <= r_zs ? ST_ZERO : ST_OK;
                    end
                end
                B_RATIO_WAIT: begin
                    if (i_div.done) begin
                        r_norm <= (q == '0) ? DVD_W'(1) : q;
                        r_p    <= 6'(DVD_W - 1);
                    end
                end
                B_NORM: begin
                    if (r_norm[DVD_W-1]) begin
                        r_m    <= r_norm[DVD_W-1 -: 32];
                        r_frac <= '0;
                        r_sq_i <= '0;
                    end else begin
                        r_norm <= {r_norm[DVD_W-2:0], 1'b0};
                        r_p    <= r_p - 1'b1;
                    end
                end
                B_SQ_UPD: begin
                    r_frac <= {r_frac[14:0], sq[32]};
                    r_m    <= sq[32] ? sq[32:1] : sq[31:0];
                    r_sq_i <= r_sq_i + 1'b1;
                end
                B_L10_UPD: begin
                    r_lg <= r_prod[37:20];
                    r_ci <= '0;
                end
                B_CV_START: begin
                    r_neg <= d[18] ^ cv_slope[15];
                    if (cv_slope == '0) begin
                        r_ppm[r_ci] <= '0;
                    end
                end
                B_CV_WAIT: begin
                    if (i_div.done) begin
                        r_e <= (r_neg ? -$signed(q[31:0]) : $signed(q[31:0]))
                               + 32'(cv_x);
                    end
                end
                B_EXP_UPD: begin
                    if (t_val[53]) begin
                        r_ppm[r_ci] <= '0;
                    end else if (t_val >= T_SAT) begin
                        r_ppm[r_ci] <= SAT24;
                    end else begin
                        r_ip  <= t_val[20:16];
                        r_f   <= t_val[15:0];
                        r_acc <= 32'(ONE_Q30);
                        r_k   <= 5'd1;
                    end
                end
                B_POW_UPD: begin
                    if (r_f[4'(5'd16 - r_k)]) begin
                        r_acc <= r_prod[61:30];
                    end
                    r_k <= r_k + 1'b1;
                end
                B_POW_FIN: begin
                    r_ppm[r_ci] <= (v25 > 25'(SAT24)) ? SAT24 : v25[RES_W-1:0];
                end
                B_CV_NEXT: begin
                    if (r_ci == 2'd2) begin
                        r_status <= r_zs ? ST_ZERO : ST_OK;
                    end else begin
                        r_ci <= r_ci + 1'b1;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= r_kind;
                        r_o_ro      <= r_ro;
                        r_o_lpg     <= r_ppm[0];
                        r_o_co      <= r_ppm[1];
                        r_o_smk     <= r_ppm[2];
                        r_o_status  <= r_status;
                        r_sum       <= '0;
                        r_cnt       <= '0;
                        r_zs        <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result_kind = r_o_kind;
    assign o_result.ro_kohm_q8  = r_o_ro;
    assign o_result.lpg_ppm     = r_o_lpg;
    assign o_result.co_ppm      = r_o_co;
    assign o_result.smoke_ppm   = r_o_smk;
    assign o_result.status      = r_o_status;
endmodule

>>> rtl/core/gspc_chk.sv
// port-level checks of the gas sensor ppm converter, bound to the top level
// depends on gas_sensor_ppm_converter_assert.svh
module gspc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [1:0]  i_out_status,
    input logic [23:0] i_lpg,
    input logic [23:0] i_co,
    input logic [23:0] i_smoke
);
    `include "gas_sensor_ppm_converter_assert.svh"

    // a stalled result stays offered
    `GSPC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid,
        "result dropped while stalled")
    // calibration results carry no concentrations
    `GSPC_ASSERT(a_cal_zero,
        i_out_valid && !i_out_kind |-> i_lpg == 0 && i_co == 0 && i_smoke == 0,
        "calibration item with nonzero ppm")
    // uncalibrated measurements report zero ppm
    `GSPC_ASSERT(a_nocal_zero,
        i_out_valid && i_out_status == 2'd1 |-> i_out_kind && i_lpg == 0 && i_co == 0 && i_smoke == 0,
        "uncalibrated item with ppm")
    // no result straight after reset
    `GSPC_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !i_out_valid, "result offered after reset")
endmodule

bind gas_sensor_ppm_converter gspc_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_kind   (o_result.result_kind),
    .i_out_status (o_result.status),
    .i_lpg        (o_result.lpg_ppm),
    .i_co         (o_result.co_ppm),
    .i_smoke      (o_result.smoke_ppm)
);
